>>> hw/rtl/bqpeq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bqpeq_pkg;

  // Sizes of the datapath
  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 20;
  localparam int FRAC_BITS   = 16;
  localparam int CHAN_BITS   = 1;
  localparam int NUM_REGS    = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CH_IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OPA_W       = COEF_BITS + 1;
  localparam int PROD_W      = OPA_W + SAMPLE_BITS;
  localparam int ACC_W       = PROD_W + 2;
  localparam int SH_W        = ACC_W - FRAC_BITS;
  localparam int STEP_W      = 4;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic        [COEF_BITS-1:0]   gain_t;
  typedef logic        [CHAN_BITS-1:0]   chan_t;
  typedef logic        [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic        [STEP_W-1:0]      step_t;
  typedef logic signed [ACC_W-1:0]       acc_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_GAIN = 3'd5
  } reg_idx_e;

  localparam coef_t COEF_B0_RST = coef_t'(65536);
  localparam gain_t GAIN_RST    = gain_t'(65536);

  // Multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_B0X,
    MUL_B1X1,
    MUL_B2X2,
    MUL_A1Y1,
    MUL_A2Y2,
    MUL_GY
  } mul_sel_e;

  // Accumulator operations
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  // Sequencer flow
  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_END
  } jmp_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     y_wr;
    logic     o_wr;
    jmp_e     jmp;
  } ucode_t;

  // Control from sequencer to datapath
  typedef struct packed {
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     latch_in;
    logic     y_wr;
    logic     o_wr;
  } ctrl_t;

  // Program steps
  localparam step_t ST_WAIT  = 4'd0;
  localparam step_t ST_M_B0  = 4'd1;
  localparam step_t ST_M_B1  = 4'd2;
  localparam step_t ST_M_B2  = 4'd3;
  localparam step_t ST_M_A1  = 4'd4;
  localparam step_t ST_M_A2  = 4'd5;
  localparam step_t ST_A_A2  = 4'd6;
  localparam step_t ST_Y_WR  = 4'd7;
  localparam step_t ST_M_G   = 4'd8;
  localparam step_t ST_O_WR  = 4'd9;

  function automatic ucode_t mk_uw(mul_sel_e m, acc_op_e a, logic y, logic o, jmp_e j);
    ucode_t w;
    w.mul_sel = m;
    w.acc_op  = a;
    w.y_wr    = y;
    w.o_wr    = o;
    w.jmp     = j;
    return w;
  endfunction

  // Control store: products are registered, so each accumulate trails its multiply
  function automatic ucode_t ucode_rom(step_t step);
    ucode_t w;
    unique case (step)
      ST_WAIT: w = mk_uw(MUL_NONE, ACC_HOLD, 1'b0, 1'b0, JMP_WAIT_IN);
      ST_M_B0: w = mk_uw(MUL_B0X,  ACC_HOLD, 1'b0, 1'b0, JMP_NEXT);
      ST_M_B1: w = mk_uw(MUL_B1X1, ACC_LOAD, 1'b0, 1'b0, JMP_NEXT);
      ST_M_B2: w = mk_uw(MUL_B2X2, ACC_ADD,  1'b0, 1'b0, JMP_NEXT);
      ST_M_A1: w = mk_uw(MUL_A1Y1, ACC_ADD,  1'b0, 1'b0, JMP_NEXT);
      ST_M_A2: w = mk_uw(MUL_A2Y2, ACC_SUB,  1'b0, 1'b0, JMP_NEXT);
      ST_A_A2: w = mk_uw(MUL_NONE, ACC_SUB,  1'b0, 1'b0, JMP_NEXT);
      ST_Y_WR: w = mk_uw(MUL_NONE, ACC_HOLD, 1'b1, 1'b0, JMP_NEXT);
      ST_M_G:  w = mk_uw(MUL_GY,   ACC_HOLD, 1'b0, 1'b0, JMP_NEXT);
      ST_O_WR: w = mk_uw(MUL_NONE, ACC_HOLD, 1'b0, 1'b1, JMP_END);
      default: w = mk_uw(MUL_NONE, ACC_HOLD, 1'b0, 1'b0, JMP_END);
    endcase
    return w;
  endfunction

  // Round half up at the binary point, then saturate to a sample
  function automatic sample_t round_sat(acc_t v);
    localparam logic signed [SH_W-1:0] S_MAX =
      SH_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SH_W-1:0] S_MIN = -S_MAX - SH_W'(1);
    acc_t                    r;
    logic signed [SH_W-1:0]  s;
    sample_t                 res;
    r = v + acc_t'(64'sd1 <<< (FRAC_BITS - 1));
    s = $signed(r[ACC_W-1:FRAC_BITS]);
    if (s > S_MAX) begin
      res = S_MAX[SAMPLE_BITS-1:0];
    end else if (s < S_MIN) begin
      res = S_MIN[SAMPLE_BITS-1:0];
    end else begin
      res = s[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bqpeq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bqpeq_in_if;
  logic                  valid;
  logic                  ready;
  bqpeq_pkg::chan_t      chan;
  bqpeq_pkg::sample_t    sample_in;

  modport source (output valid, output chan, output sample_in, input ready);
  modport sink   (input valid, input chan, input sample_in, output ready);
endinterface

interface bqpeq_out_if;
  logic                  valid;
  logic                  ready;
  bqpeq_pkg::chan_t      chan_out;
  bqpeq_pkg::sample_t    sample_out;

  modport source (output valid, output chan_out, output sample_out, input ready);
  modport sink   (input valid, input chan_out, input sample_out, output ready);
endinterface

interface bqpeq_cfg_if;
  logic                  valid;
  logic                  ready;
  bqpeq_pkg::cfg_idx_t   index;
  bqpeq_pkg::gain_t      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bqpeq_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module bqpeq_seq (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 out_free_i,
  output logic                in_ready_o,
  output bqpeq_pkg::ctrl_t    ctrl_o
);

  bqpeq_pkg::step_t  step_q, step_d;
  bqpeq_pkg::ucode_t uw;

  // Fetch the control word of the current step
  assign uw = bqpeq_pkg::ucode_rom(step_q);

  // Advance, hold for a request, or return to the start
  always_comb begin
    step_d = step_q;
    unique case (uw.jmp)
      bqpeq_pkg::JMP_NEXT: begin
        step_d = step_q + bqpeq_pkg::step_t'(1);
      end
      bqpeq_pkg::JMP_WAIT_IN: begin
        if (in_valid_i) begin
          step_d = step_q + bqpeq_pkg::step_t'(1);
        end
      end
      bqpeq_pkg::JMP_END: begin
        if (out_free_i) begin
          step_d = bqpeq_pkg::ST_WAIT;
        end
      end
      default: begin
        step_d = bqpeq_pkg::ST_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= bqpeq_pkg::ST_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  // Decode the control word into datapath strobes
  always_comb begin
    in_ready_o      = (uw.jmp == bqpeq_pkg::JMP_WAIT_IN);
    ctrl_o.mul_sel  = uw.mul_sel;
    ctrl_o.acc_op   = uw.acc_op;
    ctrl_o.latch_in = in_ready_o && in_valid_i;
    ctrl_o.y_wr     = uw.y_wr;
    ctrl_o.o_wr     = uw.o_wr && out_free_i;
  end

endmodule

`default_nettype wire

>>> hw/rtl/bqpeq_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bqpeq_dp (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  bqpeq_pkg::ctrl_t      ctrl_i,
  input  bqpeq_pkg::chan_t      chan_i,
  input  bqpeq_pkg::sample_t    sample_i,
  input  wire                   cfg_we_i,
  input  bqpeq_pkg::cfg_idx_t   cfg_idx_i,
  input  bqpeq_pkg::gain_t      cfg_data_i,
  input  wire                   out_ready_i,
  output logic                  out_valid_o,
  output logic                  out_free_o,
  output bqpeq_pkg::chan_t      out_chan_o,
  output bqpeq_pkg::sample_t    out_sample_o
);

  // Configuration registers
  bqpeq_pkg::coef_t b0_q, b1_q, b2_q, a1_q, a2_q;
  bqpeq_pkg::gain_t gain_q;

  // Per-channel history
  bqpeq_pkg::sample_t x1_q [bqpeq_pkg::CHANNELS];
  bqpeq_pkg::sample_t x2_q [bqpeq_pkg::CHANNELS];
  bqpeq_pkg::sample_t y1_q [bqpeq_pkg::CHANNELS];
  bqpeq_pkg::sample_t y2_q [bqpeq_pkg::CHANNELS];

  // Working registers
  bqpeq_pkg::chan_t   chan_q;
  bqpeq_pkg::sample_t x_q, y_q;
  logic signed [bqpeq_pkg::PROD_W-1:0] p_q, p_d;
  bqpeq_pkg::acc_t    acc_q, acc_d, p_ext;
  logic               out_valid_q, out_valid_d;
  bqpeq_pkg::chan_t   out_chan_q;
  bqpeq_pkg::sample_t out_sample_q;

  logic                                chan_ok;
  logic [bqpeq_pkg::CH_IDX_W-1:0]      ch_idx;
  logic signed [bqpeq_pkg::OPA_W-1:0]  op_a;
  bqpeq_pkg::sample_t                  op_b;
  bqpeq_pkg::sample_t                  x1_rd, x2_rd, y1_rd, y2_rd, y_new;

  // Write configuration; drop indexes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q   <= bqpeq_pkg::COEF_B0_RST;
      b1_q   <= '0;
      b2_q   <= '0;
      a1_q   <= '0;
      a2_q   <= '0;
      gain_q <= bqpeq_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bqpeq_pkg::REG_B0:   b0_q   <= $signed(cfg_data_i);
        bqpeq_pkg::REG_B1:   b1_q   <= $signed(cfg_data_i);
        bqpeq_pkg::REG_B2:   b2_q   <= $signed(cfg_data_i);
        bqpeq_pkg::REG_A1:   a1_q   <= $signed(cfg_data_i);
        bqpeq_pkg::REG_A2:   a2_q   <= $signed(cfg_data_i);
        bqpeq_pkg::REG_GAIN: gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      chan_q <= chan_i;
      x_q    <= sample_i;
    end
  end

  // Select the channel history; a channel beyond the range reads zero
  assign chan_ok = (32'(chan_q) < bqpeq_pkg::CHANNELS);
  assign ch_idx  = bqpeq_pkg::CH_IDX_W'(chan_q);
  assign x1_rd   = chan_ok ? x1_q[ch_idx] : '0;
  assign x2_rd   = chan_ok ? x2_q[ch_idx] : '0;
  assign y1_rd   = chan_ok ? y1_q[ch_idx] : '0;
  assign y2_rd   = chan_ok ? y2_q[ch_idx] : '0;

  // Steer the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl_i.mul_sel)
      bqpeq_pkg::MUL_B0X: begin
        op_a = bqpeq_pkg::OPA_W'(b0_q);
        op_b = x_q;
      end
      bqpeq_pkg::MUL_B1X1: begin
        op_a = bqpeq_pkg::OPA_W'(b1_q);
        op_b = x1_rd;
      end
      bqpeq_pkg::MUL_B2X2: begin
        op_a = bqpeq_pkg::OPA_W'(b2_q);
        op_b = x2_rd;
      end
      bqpeq_pkg::MUL_A1Y1: begin
        op_a = bqpeq_pkg::OPA_W'(a1_q);
        op_b = y1_rd;
      end
      bqpeq_pkg::MUL_A2Y2: begin
        op_a = bqpeq_pkg::OPA_W'(a2_q);
        op_b = y2_rd;
      end
      bqpeq_pkg::MUL_GY: begin
        op_a = $signed({1'b0, gain_q});
        op_b = y_q;
      end
      default: ;
    endcase
  end

  assign p_d = op_a * op_b;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_sel != bqpeq_pkg::MUL_NONE) begin
      p_q <= p_d;
    end
  end

  // Accumulate the registered product
  assign p_ext = bqpeq_pkg::ACC_W'(p_q);

  always_comb begin
    acc_d = acc_q;
    case (ctrl_i.acc_op)
      bqpeq_pkg::ACC_LOAD: acc_d = p_ext;
      bqpeq_pkg::ACC_ADD:  acc_d = acc_q + p_ext;
      bqpeq_pkg::ACC_SUB:  acc_d = acc_q - p_ext;
      default:             acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Round and saturate the filter output
  assign y_new = bqpeq_pkg::round_sat(acc_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.y_wr) begin
      y_q <= y_new;
    end
  end

  // Shift the history of the active channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < bqpeq_pkg::CHANNELS; c++) begin
        x1_q[c] <= '0;
        x2_q[c] <= '0;
        y1_q[c] <= '0;
        y2_q[c] <= '0;
      end
    end else if (ctrl_i.y_wr && chan_ok) begin
      x2_q[ch_idx] <= x1_q[ch_idx];
      x1_q[ch_idx] <= x_q;
      y2_q[ch_idx] <= y1_q[ch_idx];
      y1_q[ch_idx] <= y_new;
    end
  end

  // Hold the result until the sink takes it
  assign out_free_o  = !out_valid_q || out_ready_i;
  assign out_valid_d = ctrl_i.o_wr ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.o_wr) begin
      out_chan_q   <= chan_q;
      out_sample_q <= chan_ok ? bqpeq_pkg::round_sat(p_ext) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_chan_o   = out_chan_q;
  assign out_sample_o = out_sample_q;

endmodule

`default_nettype wire

>>> hw/rtl/biquad_peaking_eq_multichannel.sv
// Each request runs through the ten-step control program that drives one
// shared 21x24 multiplier and one accumulator; a new request is taken only
// after the last step writes the result, which stalls until the output register is free.
// The input is taken again while a finished result waits in the output register.
// Reset (asynchronous, active low) clears all channel history, loads b0 and the
// output gain with 1.0 and the other coefficients with zero.
`timescale 1ns / 1ps
`default_nettype none

module biquad_peaking_eq_multichannel (
  input  wire           clk_i,
  input  wire           rst_ni,
  bqpeq_in_if.sink      in_i,
  bqpeq_out_if.source   out_o,
  bqpeq_cfg_if.sink     cfg_i
);

  bqpeq_pkg::ctrl_t ctrl;
  logic             out_free;
  logic             in_ready;

  // Configuration is always taken
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  bqpeq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_free_i (out_free),
    .in_ready_o (in_ready),
    .ctrl_o     (ctrl)
  );

  bqpeq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .chan_i       (in_i.chan),
    .sample_i     (in_i.sample_in),
    .cfg_we_i     (cfg_i.valid),
    .cfg_idx_i    (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_free_o   (out_free),
    .out_chan_o   (out_o.chan_out),
    .out_sample_o (out_o.sample_out)
  );

  // One request in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request accepted while another is in flight");

  // Never overwrite a result the sink has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.o_wr |-> (!out_o.valid || out_o.ready))
    else $error("output register overwritten");

  // Capture, history update and result write fall on distinct steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.latch_in, ctrl.y_wr, ctrl.o_wr}))
    else $error("conflicting sequencer strobes");

endmodule

`default_nettype wire
